[hdl/crsf_frame_parser_top_assert.svh]
// Assertion macros for the frame parser
`ifndef CRSF_FRAME_PARSER_TOP_ASSERT_SVH
`define CRSF_FRAME_PARSER_TOP_ASSERT_SVH

// same-cycle implication
`define CRSF_AST_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CRSF_AST_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/crsf_pkg.sv]
package crsf_pkg;

	typedef logic [1:0] kind_t;

	localparam kind_t KIND_CHAN    = 2'd0;
	localparam kind_t KIND_STAT    = 2'd1;
	localparam kind_t KIND_LEN_ERR = 2'd2;
	localparam kind_t KIND_CRC_ERR = 2'd3;

	typedef logic [1:0] reg_idx_t;

	localparam reg_idx_t REG_SYNC      = 2'd0;
	localparam reg_idx_t REG_CHAN_TYPE = 2'd1;
	localparam reg_idx_t REG_STAT_TYPE = 2'd2;
	localparam reg_idx_t REG_STAT_EN   = 2'd3;

	localparam logic [7:0] SYNC_RST      = 8'd200;
	localparam logic [7:0] CHAN_TYPE_RST = 8'd22;
	localparam logic [7:0] STAT_TYPE_RST = 8'd20;
	localparam logic       STAT_EN_RST   = 1'b1;

	localparam logic [7:0] CRC_POLY = 8'hD5;
	localparam logic [7:0] MIN_LEN  = 8'd3;
	localparam int         CHAN_W   = 11;
	localparam int         MAX_RES  = 16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CRC,
		ST_ERR,
		ST_DEC
	} st_t;

endpackage

[hdl/crsf_rx_if.sv]
interface crsf_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

[hdl/crsf_res_if.sv]
interface crsf_res_if;
	import crsf_pkg::*;

	logic        valid;
	logic        ready;
	kind_t       kind;
	logic [3:0]  item_index;
	logic [10:0] item_value;
	logic        last;

	modport source (output valid, output kind, output item_index, output item_value,
		output last, input ready);
	modport sink (input valid, input kind, input item_index, input item_value,
		input last, output ready);
endinterface

[hdl/crsf_cfg_if.sv]
interface crsf_cfg_if;
	import crsf_pkg::*;

	logic       valid;
	logic       ready;
	reg_idx_t   index;
	logic [7:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/crsf_ram.sv]
module crsf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 22
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[hdl/crsf_frame_parser_top.sv]
// Frame parser: sync, length and framing bytes are taken in the idle state; a type or
// payload byte is taken and then runs 8 steps of the bit-serial CRC unit.
// An error goes through ST_ERR into the output register once that is free.
// A decode reads the payload RAM one byte at a time, issue then capture.
// Reset: config to defaults, hunting, payload store marked empty (reads as
// zero) at once through per-entry valid flags; no clearing pass.
module crsf_frame_parser_top #(
	parameter int PAYLOAD_BYTES = 22,
	parameter int CHANNEL_COUNT = 16,
	parameter int STATS_BYTES   = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	crsf_rx_if.sink    rx,
	crsf_res_if.source res,
	crsf_cfg_if.sink   cfg
);
	import crsf_pkg::*;

	`include "crsf_frame_parser_top_assert.svh"

	localparam int AW     = $clog2(PAYLOAD_BYTES);
	localparam int PW     = $clog2(PAYLOAD_BYTES + 2);
	localparam int STAT_N = (STATS_BYTES < MAX_RES) ? STATS_BYTES : MAX_RES;
	localparam int ACC_W  = CHAN_W + 7;

	// config
	logic [7:0] sync_q, chan_type_q, stat_type_q;
	logic       stat_en_q;

	// control
	st_t                state_q, state_d;
	logic               in_frame_q;
	logic [7:0]         len_q;
	logic [PW-1:0]      pos_q;
	logic [7:0]         kind_q;
	logic [7:0]         crc_q;
	logic [2:0]         bit_q;
	kind_t              err_kind_q;
	logic               dec_chan_q;
	logic [ACC_W-1:0]   acc_q;
	logic [4:0]         nb_q;
	logic [3:0]         cnt_q;
	logic [AW-1:0]      rd_ptr_q;
	logic               rd_pend_q;
	logic               rd_vld_q;
	logic [PAYLOAD_BYTES-1:0] vld_q;

	// output register
	logic        out_valid_q;
	kind_t       out_kind_q;
	logic [3:0]  out_idx_q;
	logic [10:0] out_val_q;
	logic        out_last_q;

	logic          rx_acc, is_sync, len_bad, body, crc_ok, dec_match;
	logic [PW-1:0] p_idx;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_rdata;
	logic [7:0]    crc_step;
	logic          out_free, have, emit, rd_issue, err_ld, dec_last;
	logic [4:0]    thr;
	logic [3:0]    total_m1;
	kind_t         gen_kind;
	logic [3:0]    gen_idx;
	logic [10:0]   gen_val;
	logic          gen_last;

	assign cfg.ready = 1'b1;

	assign rx_acc    = rx.valid && rx.ready;
	assign is_sync   = rx.rx_byte == sync_q;
	assign len_bad   = (rx.rx_byte < MIN_LEN) ||
		({1'b0, rx.rx_byte} > 9'(PAYLOAD_BYTES + 2));
	assign body      = (9'(pos_q) + 9'd1) < {1'b0, len_q};
	assign crc_ok    = rx.rx_byte == crc_q;
	assign dec_match = (kind_q == chan_type_q) || ((kind_q == stat_type_q) && stat_en_q);
	assign p_idx     = pos_q - PW'(1);
	assign crc_step  = crc_q[7] ? ((crc_q << 1) ^ CRC_POLY) : (crc_q << 1);

	assign ram_we    = rx_acc && in_frame_q && !is_sync && (len_q != 8'd0) && body &&
		(pos_q != '0) && (p_idx < PW'(PAYLOAD_BYTES));
	assign ram_waddr = AW'(p_idx);

	crsf_ram #(
		.WIDTH (8),
		.DEPTH (PAYLOAD_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (rx.rx_byte),
		.raddr (rd_ptr_q),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (rx_acc && in_frame_q && !is_sync) begin
					if (len_q == 8'd0) begin
						if (len_bad) begin
							state_d = ST_ERR;
						end
					end else if (body) begin
						state_d = ST_CRC;
					end else if (!crc_ok) begin
						state_d = ST_ERR;
					end else if (dec_match) begin
						state_d = ST_DEC;
					end
				end
			end
			ST_CRC: begin
				if (bit_q == 3'd7) begin
					state_d = ST_IDLE;
				end
			end
			ST_ERR: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_DEC: begin
				if (emit && dec_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		rx.ready = state_q == ST_IDLE;
		out_free = !out_valid_q || res.ready;
		thr      = dec_chan_q ? 5'(CHAN_W) : 5'd8;
		total_m1 = dec_chan_q ? 4'(CHANNEL_COUNT - 1) : 4'(STAT_N - 1);
		have     = nb_q >= thr;
		dec_last = cnt_q == total_m1;
		emit     = (state_q == ST_DEC) && !rd_pend_q && have && out_free;
		rd_issue = (state_q == ST_DEC) && !rd_pend_q && !have;
		err_ld   = (state_q == ST_ERR) && out_free;
		if (err_ld) begin
			gen_kind = err_kind_q;
			gen_idx  = '0;
			gen_val  = '0;
			gen_last = 1'b1;
		end else begin
			gen_kind = dec_chan_q ? KIND_CHAN : KIND_STAT;
			gen_idx  = cnt_q;
			gen_val  = dec_chan_q ? acc_q[10:0] : {3'b000, acc_q[7:0]};
			gen_last = dec_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q      <= SYNC_RST;
			chan_type_q <= CHAN_TYPE_RST;
			stat_type_q <= STAT_TYPE_RST;
			stat_en_q   <= STAT_EN_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_SYNC:      sync_q      <= cfg.data;
				REG_CHAN_TYPE: chan_type_q <= cfg.data;
				REG_STAT_TYPE: stat_type_q <= cfg.data;
				REG_STAT_EN:   stat_en_q   <= cfg.data[0];
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_frame_q <= 1'b0;
			len_q      <= '0;
			pos_q      <= '0;
			kind_q     <= '0;
			crc_q      <= '0;
			bit_q      <= '0;
			err_kind_q <= KIND_LEN_ERR;
			dec_chan_q <= 1'b0;
			acc_q      <= '0;
			nb_q       <= '0;
			cnt_q      <= '0;
			rd_ptr_q   <= '0;
			rd_pend_q  <= 1'b0;
			rd_vld_q   <= 1'b0;
			vld_q      <= '0;
		end else begin
			state_q <= state_d;
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			if (rx_acc) begin
				if (!in_frame_q) begin
					if (is_sync) begin
						in_frame_q <= 1'b1;
						pos_q      <= '0;
						len_q      <= '0;
					end
				end else if (is_sync) begin
					len_q <= '0;
					pos_q <= '0;
				end else if (len_q == 8'd0) begin
					pos_q <= '0;
					if (len_bad) begin
						in_frame_q <= 1'b0;
						err_kind_q <= KIND_LEN_ERR;
					end else begin
						len_q <= rx.rx_byte;
					end
				end else if (body) begin
					if (pos_q == '0) begin
						kind_q <= rx.rx_byte;
						crc_q  <= rx.rx_byte;
					end else begin
						crc_q <= crc_q ^ rx.rx_byte;
					end
					pos_q <= pos_q + PW'(1);
					bit_q <= '0;
				end else begin
					// check byte
					len_q      <= '0;
					pos_q      <= '0;
					in_frame_q <= 1'b0;
					err_kind_q <= KIND_CRC_ERR;
					dec_chan_q <= kind_q == chan_type_q;
					acc_q      <= '0;
					nb_q       <= '0;
					cnt_q      <= '0;
					rd_ptr_q   <= '0;
					rd_pend_q  <= 1'b0;
				end
			end
			if (state_q == ST_CRC) begin
				crc_q <= crc_step;
				bit_q <= bit_q + 3'd1;
			end
			if (rd_issue) begin
				rd_pend_q <= 1'b1;
				rd_vld_q  <= vld_q[rd_ptr_q];
				rd_ptr_q  <= rd_ptr_q + AW'(1);
			end
			if (rd_pend_q) begin
				acc_q     <= acc_q | (ACC_W'(ram_rdata & {8{rd_vld_q}}) << nb_q);
				nb_q      <= nb_q + 5'd8;
				rd_pend_q <= 1'b0;
			end
			if (emit) begin
				acc_q <= acc_q >> thr;
				nb_q  <= nb_q - thr;
				cnt_q <= cnt_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit || err_ld) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit || err_ld) begin
			out_kind_q <= gen_kind;
			out_idx_q  <= gen_idx;
			out_val_q  <= gen_val;
			out_last_q <= gen_last;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.kind       = out_kind_q;
	assign res.item_index = out_idx_q;
	assign res.item_value = out_val_q;
	assign res.last       = out_last_q;

	`CRSF_AST_NXT(a_crc_done, state_q == ST_CRC && bit_q == 3'd7, state_q == ST_IDLE, "crc unit overran")
	`CRSF_AST_IMP(a_wr_rng, ram_we, 7'(ram_waddr) < 7'(PAYLOAD_BYTES), "store write out of range")
	`CRSF_AST_IMP(a_pend_need, state_q == ST_DEC && rd_pend_q, nb_q < 5'd11, "read while bits held")
	`CRSF_AST_IMP(a_err_hunt, state_q == ST_ERR, !in_frame_q, "error with frame open")
endmodule

[verif/crsf_frame_parser_top_test.sv]
module crsf_frame_parser_top_test;
	import crsf_pkg::*;

	localparam int PAYLOAD_BYTES = 22;
	localparam int CHANNEL_COUNT = 16;
	localparam int STATS_BYTES   = 10;
	localparam int SETTLE_CYCLES = 64;
	localparam int HOLD_CYCLES   = 600;
	localparam int CYCLE_LIMIT   = 400000;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  idx;
		logic [10:0] value;
		logic        last;
	} parse_res_t;

	logic clk = 1'b0;
	logic arst_n;

	crsf_rx_if  rx();
	crsf_res_if res();
	crsf_cfg_if cfg();

	crsf_frame_parser_top #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES),
		.CHANNEL_COUNT(CHANNEL_COUNT),
		.STATS_BYTES(STATS_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx),
		.res(res),
		.cfg(cfg)
	);

	always #1 clk = ~clk;

	// parser copy: registers
	logic [7:0] sync_val  = SYNC_RST;
	logic [7:0] chan_type = CHAN_TYPE_RST;
	logic [7:0] stat_type = STAT_TYPE_RST;
	logic       stat_en   = STAT_EN_RST;

	// parser copy: frame state
	logic       in_frame = 1'b0;
	int         body_pos = 0;
	logic [7:0] frm_len  = 8'd0;
	logic [7:0] frm_type = 8'd0;
	logic [7:0] run_crc  = 8'd0;
	logic [7:0] payload_mem [PAYLOAD_BYTES] = '{default: 8'h00};

	parse_res_t decoded_q [$];

	int   tx_gap_pct   = 0;
	int   rx_stall_pct = 0;
	int   bytes_sent   = 0;
	int   fail_count   = 0;
	int   cycle_count  = 0;
	logic hold_req     = 1'b0;
	logic hold_res     = 1'b0;
	parse_res_t want, got;

	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++)
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		return c;
	endfunction

	function automatic void emit(input kind_t kind, input int idx, input logic [10:0] value,
		input logic last);
		parse_res_t r;
		r.kind  = kind;
		r.idx   = 4'(idx);
		r.value = value;
		r.last  = last;
		decoded_q.push_back(r);
	endfunction

	function automatic void parse_byte(input logic [7:0] b);
		logic [PAYLOAD_BYTES*8+7:0] bits;
		if (!in_frame) begin
			if (b == sync_val) begin
				in_frame = 1'b1;
				body_pos = 0;
				frm_len  = 8'd0;
			end
			return;
		end
		if (b == sync_val) begin
			frm_len  = 8'd0;
			body_pos = 0;
			return;
		end
		if (frm_len == 8'd0) begin
			if (b < MIN_LEN || int'(b) > PAYLOAD_BYTES + 2) begin
				in_frame = 1'b0;
				body_pos = 0;
				emit(KIND_LEN_ERR, 0, 11'd0, 1'b1);
			end else begin
				frm_len  = b;
				body_pos = 0;
			end
			return;
		end
		if (body_pos + 1 < int'(frm_len)) begin
			if (body_pos == 0) begin
				frm_type = b;
				run_crc  = crc8_step(8'h00, b);
			end else begin
				payload_mem[body_pos - 1] = b;
				run_crc = crc8_step(run_crc, b);
			end
			body_pos++;
			return;
		end
		// crc byte closes the frame
		in_frame = 1'b0;
		body_pos = 0;
		frm_len  = 8'd0;
		if (b != run_crc) begin
			emit(KIND_CRC_ERR, 0, 11'd0, 1'b1);
		end else if (frm_type == chan_type) begin
			bits = '0;
			for (int j = 0; j < PAYLOAD_BYTES; j++)
				bits[j*8 +: 8] = payload_mem[j];
			for (int i = 0; i < CHANNEL_COUNT && i < MAX_RES; i++)
				emit(KIND_CHAN, i, bits[i*CHAN_W +: CHAN_W],
					i == CHANNEL_COUNT - 1 || i == MAX_RES - 1);
		end else if (frm_type == stat_type && stat_en) begin
			for (int i = 0; i < STATS_BYTES && i < MAX_RES; i++)
				emit(KIND_STAT, i, {3'd0, payload_mem[i]},
					i == STATS_BYTES - 1 || i == MAX_RES - 1);
		end
	endfunction

	// receiver side
	always @(posedge clk)
		res.ready <= !hold_res && ($urandom_range(0, 99) >= rx_stall_pct);

	initial begin
		forever begin
			wait (hold_req);
			hold_req = 1'b0;
			hold_res <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_res <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (res.valid === 1'b1 && res.ready) begin
			got = '{res.kind, res.item_index, res.item_value, res.last};
			if (decoded_q.size() == 0) begin
				$display("%0t: unexpected result kind %0d index %0d value %0d last %0d",
					$time, got.kind, got.idx, got.value, got.last);
				fail_count++;
			end else begin
				want = decoded_q.pop_front();
				if (got !== want) begin
					$display("%0t: expected kind %0d index %0d value %0d last %0d, %s",
						$time, want.kind, want.idx, want.value, want.last, "got");
					$display("%0t:   actual kind %0d index %0d value %0d last %0d",
						$time, got.kind, got.idx, got.value, got.last);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < tx_gap_pct) begin
			rx.valid <= 1'b0;
			@(posedge clk);
		end
		rx.valid   <= 1'b1;
		rx.rx_byte <= b;
		@(posedge clk);
		while (!rx.ready) @(posedge clk);
		bytes_sent++;
		parse_byte(b);
	endtask

	function automatic logic [7:0] body_byte();
		logic [7:0] b;
		b = 8'($urandom);
		if (b == sync_val && $urandom_range(0, 9) != 0)
			b ^= 8'h01;
		return b;
	endfunction

	// fill < 0 gives random payload
	task automatic send_frame(input logic [7:0] ftype, input int plen, input bit bad_crc,
		input int fill);
		logic [7:0] crc;
		logic [7:0] b;
		crc = crc8_step(8'h00, ftype);
		send_byte(sync_val);
		send_byte(8'(plen + 2));
		send_byte(ftype);
		for (int k = 0; k < plen; k++) begin
			b = (fill < 0) ? body_byte() : 8'(fill);
			crc = crc8_step(crc, b);
			send_byte(b);
		end
		if (bad_crc)
			crc ^= 8'(1 << $urandom_range(0, 7));
		send_byte(crc);
	endtask

	task automatic send_random_frame();
		int pick;
		int plen;
		pick = $urandom_range(0, 99);
		plen = ($urandom_range(0, 9) < 6) ? PAYLOAD_BYTES : $urandom_range(1, PAYLOAD_BYTES);
		if (pick < 45) begin
			send_frame(chan_type, plen, 1'b0, -1);
		end else if (pick < 68) begin
			send_frame(stat_type, $urandom_range(1, PAYLOAD_BYTES), 1'b0, -1);
		end else if (pick < 75) begin
			send_frame(body_byte(), $urandom_range(1, PAYLOAD_BYTES), 1'b0, -1);
		end else if (pick < 83) begin
			send_frame($urandom_range(0, 1) ? chan_type : stat_type,
				$urandom_range(1, PAYLOAD_BYTES), 1'b1, -1);
		end else if (pick < 89) begin
			send_byte(sync_val);
			send_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 2))
				: 8'($urandom_range(PAYLOAD_BYTES + 3, 255)));
		end else if (pick < 95) begin
			// frame that a fresh sync may cut short
			send_byte(sync_val);
			send_byte(8'($urandom_range(3, PAYLOAD_BYTES + 2)));
			repeat ($urandom_range(0, 6)) send_byte(body_byte());
			send_frame(chan_type, plen, 1'b0, -1);
		end else begin
			repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
		end
	endtask

	task automatic settle();
		rx.valid <= 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_registers(input logic [7:0] s, input logic [7:0] c,
		input logic [7:0] t, input logic e);
		logic [7:0] vals [4];
		vals = '{s, c, t, {7'($urandom), e}};
		settle();
		for (int k = 0; k < 4; k++) begin
			cfg.valid <= 1'b1;
			cfg.index <= reg_idx_t'(k);
			cfg.data  <= vals[k];
			@(posedge clk);
			while (!cfg.ready) @(posedge clk);
			case (reg_idx_t'(k))
				REG_SYNC:      sync_val  = vals[k];
				REG_CHAN_TYPE: chan_type = vals[k];
				REG_STAT_TYPE: stat_type = vals[k];
				REG_STAT_EN:   stat_en   = vals[k][0];
			endcase
		end
		cfg.valid <= 1'b0;
	endtask

	task automatic test_random_traffic(input int n);
		int stop_at;
		stop_at = bytes_sent + n;
		while (bytes_sent < stop_at) send_random_frame();
	endtask

	task automatic test_directed_frames();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(sync_val);
		send_byte(MIN_LEN - 8'd1);
		send_byte(sync_val);
		send_byte(8'(PAYLOAD_BYTES + 3));
		// sync as a body byte restarts; short channels frame uses stale payload
		send_byte(sync_val);
		send_byte(8'd5);
		send_frame(chan_type, 1, 1'b0, 8'hFF);
		send_frame(stat_type, 1, 1'b0, 8'h00);
		send_frame(8'h55, 1, 1'b1, 8'h12);
	endtask

	task automatic test_register_settings();
		load_registers(8'h00, 8'hFF, 8'h01, 1'b0);
		test_random_traffic(25);
		load_registers(8'hFF, 8'h00, 8'hFE, 1'b1);
		test_random_traffic(25);
		// equal type codes decode as channels
		load_registers(SYNC_RST, CHAN_TYPE_RST, CHAN_TYPE_RST, 1'b1);
		test_random_traffic(25);
		load_registers(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
		test_random_traffic(25);
		load_registers(SYNC_RST, CHAN_TYPE_RST, STAT_TYPE_RST, STAT_EN_RST);
	endtask

	task automatic test_output_backpressure();
		hold_req = 1'b1;
		repeat (3) send_frame(chan_type, PAYLOAD_BYTES, 1'b0, -1);
	endtask

	initial begin
		arst_n     = 1'b0;
		rx.valid   = 1'b0;
		rx.rx_byte = 8'h00;
		cfg.valid  = 1'b0;
		cfg.index  = REG_SYNC;
		cfg.data   = 8'h00;
		res.ready  = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_gap_pct   = 28;
		rx_stall_pct = 57;
		test_directed_frames();
		test_random_traffic(60);
		test_register_settings();

		tx_gap_pct   = 57;
		rx_stall_pct = 28;
		test_random_traffic(60);
		test_output_backpressure();

		tx_gap_pct   = 0;
		rx_stall_pct = 0;
		test_random_traffic(60);

		settle();
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
